@@ rtl/fmbq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Front-middle-back queue package
// Shared constants, operation codes and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int OCC_W        = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_MIDDLE = 3'd1,
        OP_PUSH_BACK   = 3'd2,
        OP_POP_FRONT   = 3'd3,
        OP_POP_MIDDLE  = 3'd4,
        OP_POP_BACK    = 3'd5
    } t_op;

    typedef struct packed {
        logic load;       // latch the request
        logic rd_target;  // read the entry a pop removes
        logic rd_shift;   // read the next entry to move
        logic wr_shift;   // write the moved entry
        logic wr_value;   // write the pushed value
        logic cap_pop;    // capture the removed value
        logic commit;     // update count and head, load the result
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic full;
        logic empty;
        logic more;       // entries still to move
        logic out_free;   // result register can take a new result
    } t_status;

endpackage : fmbq_pkg
`default_nettype wire

@@ rtl/fmbq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fmbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : fmbq_ram
`default_nettype wire

@@ rtl/fmbq_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Front-middle-back queue datapath
// Circular buffer in RAM with head pointer and count, entry mover for the
// middle operations, and the result register.
// ----------------------------------------------------------------------------
module fmbq_datapath #(
    parameter int CAPACITY = fmbq_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fmbq_pkg::t_cmd                i_cmd,
    output fmbq_pkg::t_status                  o_status,
    input  wire logic [fmbq_pkg::OP_W-1:0]     i_operation,
    input  wire logic signed [fmbq_pkg::DATA_W-1:0] i_push_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [fmbq_pkg::DATA_W-1:0] o_popped_value,
    output logic                               o_was_empty,
    output logic                               o_was_full,
    output logic [fmbq_pkg::OCC_W-1:0]         o_occupancy
);
    import fmbq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_head;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_val;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_left;
    logic [AW-1:0]     r_dst;
    logic [DATA_W-1:0] r_popped;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_empty;
    logic              r_out_full;
    logic [OCC_W-1:0]  r_out_occ;

    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     half;
    logic [CW-1:0]     half_m1;
    logic [CW-1:0]     left_push_mid;
    logic [CW-1:0]     left_pop_mid;
    logic [AW-1:0]     n_pos;
    logic [AW-1:0]     n_idx;
    logic [AW-1:0]     n_left;
    logic [AW-1:0]     head_m1;
    logic [AW-1:0]     head_p1;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;
    logic              is_push;
    logic              is_pop;
    logic              full;
    logic              empty;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     n_head;
    logic [DATA_W-1:0] n_value;
    logic [CW+OCC_W-1:0] occ_ext;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] lidx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lidx};
        if (s >= (AW+1)'(CAPACITY)) begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign cnt_m1        = r_count - CW'(1);
    assign half          = r_count >> 1;
    assign half_m1       = cnt_m1 >> 1;
    assign left_push_mid = r_count - half;
    assign left_pop_mid  = cnt_m1 - half_m1;

    always_comb begin
        n_pos  = '0;
        n_idx  = '0;
        n_left = '0;
        case (i_operation)
            OP_PUSH_MIDDLE: begin
                n_pos  = half[AW-1:0];
                n_idx  = cnt_m1[AW-1:0];
                n_left = left_push_mid[AW-1:0];
            end
            OP_PUSH_BACK: begin
                n_pos = r_count[AW-1:0];
            end
            OP_POP_MIDDLE: begin
                n_pos  = half_m1[AW-1:0];
                n_idx  = half_m1[AW-1:0] + AW'(1);
                n_left = left_pop_mid[AW-1:0];
            end
            OP_POP_BACK: begin
                n_pos = cnt_m1[AW-1:0];
            end
            default: begin
                n_pos = '0;
            end
        endcase
    end

    assign is_push = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_MIDDLE)
                  || (r_op == OP_PUSH_BACK);
    assign is_pop  = (r_op == OP_POP_FRONT) || (r_op == OP_POP_MIDDLE)
                  || (r_op == OP_POP_BACK);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);

    assign o_status.is_push  = is_push;
    assign o_status.is_pop   = is_pop;
    assign o_status.full     = full;
    assign o_status.empty    = empty;
    assign o_status.more     = (r_left != '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign head_m1 = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign head_p1 = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);

    assign rd_addr = i_cmd.rd_shift ? f_phys(r_head, r_idx) : f_phys(r_head, r_pos);
    assign wr_addr = i_cmd.wr_shift ? r_dst
                   : (r_op == OP_PUSH_FRONT) ? head_m1 : f_phys(r_head, r_pos);
    assign wr_data = i_cmd.wr_shift ? rd_data : r_val;

    fmbq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_shift || i_cmd.wr_value),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_shift || i_cmd.rd_target),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_value = '0;
        if (is_push && !full) begin
            n_count = r_count + CW'(1);
            if (r_op == OP_PUSH_FRONT) begin
                n_head = head_m1;
            end
        end else if (is_pop && empty) begin
            n_value = '1;
        end else if (is_pop) begin
            n_count = cnt_m1;
            n_value = r_popped;
            if (r_op == OP_POP_FRONT) begin
                n_head = head_p1;
            end
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_head      <= n_head;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_val  <= i_push_value;
            r_pos  <= n_pos;
            r_idx  <= n_idx;
            r_left <= n_left;
        end else if (i_cmd.rd_shift) begin
            if (is_push) begin
                r_idx <= r_idx - AW'(1);
                r_dst <= f_phys(r_head, r_idx + AW'(1));
            end else begin
                r_idx <= r_idx + AW'(1);
                r_dst <= f_phys(r_head, r_idx - AW'(1));
            end
            r_left <= r_left - AW'(1);
        end
        if (i_cmd.cap_pop) begin
            r_popped <= rd_data;
        end
        if (i_cmd.commit) begin
            r_out_value <= n_value;
            r_out_empty <= is_pop && empty;
            r_out_full  <= is_push && full;
            r_out_occ   <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_was_empty    = r_out_empty;
    assign o_was_full     = r_out_full;
    assign o_occupancy    = r_out_occ;

endmodule : fmbq_datapath
`default_nettype wire

@@ rtl/fmbq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Front-middle-back queue controller
// Steps one request through decode, entry moves, write or read, and result.
// ----------------------------------------------------------------------------
module fmbq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fmbq_pkg::t_status i_status,
    output fmbq_pkg::t_cmd         o_cmd
);
    import fmbq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_POP_RD,
        S_POP_CAP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.is_push && !i_status.full) begin
                    n_state = i_status.more ? S_SHIFT_RD : S_WRITE;
                end else if (i_status.is_pop && !i_status.empty) begin
                    n_state = S_POP_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT_RD: begin
                o_cmd.rd_shift = 1'b1;
                n_state        = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                if (i_status.more) begin
                    n_state = S_SHIFT_RD;
                end else if (i_status.is_push) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WRITE: begin
                o_cmd.wr_value = 1'b1;
                n_state        = S_FINISH;
            end
            S_POP_RD: begin
                o_cmd.rd_target = 1'b1;
                n_state         = S_POP_CAP;
            end
            S_POP_CAP: begin
                o_cmd.cap_pop = 1'b1;
                n_state       = i_status.more ? S_SHIFT_RD : S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule : fmbq_ctrl
`default_nettype wire

@@ rtl/front_middle_back_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Front-middle-back queue
// Ordered store of signed words with push and pop at front, middle and back.
// ----------------------------------------------------------------------------
// One request is in work at a time; each gives one result. Entries live in a
// circular buffer in a single RAM, so front and back operations take no
// entry moves. Middle operations move the entries behind the middle one
// position through the RAM's read and write ports, reading each entry and
// then writing it: push middle moves ceil(n/2) entries and pop middle
// floor(n/2), where n is the count before the request. A new request is
// taken while the previous result still waits. The RAM needs no clearing
// after reset; only occupied entries are read.
// ----------------------------------------------------------------------------
module front_middle_back_queue #(
    parameter int CAPACITY = fmbq_pkg::CAPACITY_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [fmbq_pkg::OP_W-1:0]          i_operation,
    input  wire logic signed [fmbq_pkg::DATA_W-1:0] i_push_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [fmbq_pkg::DATA_W-1:0]      o_popped_value,
    output logic                                    o_was_empty,
    output logic                                    o_was_full,
    output logic [fmbq_pkg::OCC_W-1:0]              o_occupancy
);
    import fmbq_pkg::*;

    t_cmd    cmd;
    t_status status;

    fmbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fmbq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_was_empty    (o_was_empty),
        .o_was_full     (o_was_full),
        .o_occupancy    (o_occupancy)
    );

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in work");

    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_empty) |-> (o_popped_value == '1))
        else $error("empty pop without all-ones answer");

    a_full_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_full) |-> (o_popped_value == '0) && !o_was_empty)
        else $error("dropped push with bad answer");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before delivery");

endmodule : front_middle_back_queue
`default_nettype wire

@@ sim/fmbq_checker.sv @@
// ----------------------------------------------------------------------------
// Front-middle-back queue checker
// Watches the request and result channels, keeps a shadow copy of the stored sequence,
// predicts the result of every accepted request and compares each accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module fmbq_checker
    import fmbq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    input  wire logic [OP_W-1:0]           i_operation,
    input  wire logic signed [DATA_W-1:0]  i_push_value,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic signed [DATA_W-1:0]  i_popped_value,
    input  wire logic                      i_was_empty,
    input  wire logic                      i_was_full,
    input  wire logic [OCC_W-1:0]          i_occupancy,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     was_empty;
        logic                     was_full;
        logic [OCC_W-1:0]         occupancy;
    } t_queue_result;

    logic signed [DATA_W-1:0] shadow_seq[$];
    t_queue_result            awaited_results[$];
    t_queue_result            predicted;
    int                       fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
        fails++;
    endtask

    function automatic t_queue_result apply_request(input logic [OP_W-1:0] op,
                                                    input logic signed [DATA_W-1:0] val);
        t_queue_result r;
        int            idx;
        r = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
                if (shadow_seq.size() >= CAPACITY) begin
                    r.was_full = 1'b1;
                end else if (op == OP_PUSH_FRONT) begin
                    shadow_seq.push_front(val);
                end else if (op == OP_PUSH_MIDDLE) begin
                    shadow_seq.insert(shadow_seq.size() / 2, val);
                end else begin
                    shadow_seq = {shadow_seq, val};
                end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
                if (shadow_seq.size() == 0) begin
                    r.was_empty    = 1'b1;
                    r.popped_value = -1;
                end else if (op == OP_POP_FRONT) begin
                    r.popped_value = shadow_seq.pop_front();
                end else if (op == OP_POP_MIDDLE) begin
                    idx            = (shadow_seq.size() - 1) / 2;
                    r.popped_value = shadow_seq[idx];
                    shadow_seq.delete(idx);
                end else begin
                    idx            = shadow_seq.size() - 1;
                    r.popped_value = shadow_seq[idx];
                    shadow_seq.delete(idx);
                end
            end
            default: begin
            end
        endcase
        r.occupancy = OCC_W'(shadow_seq.size());
        return r;
    endfunction

    task automatic check_result(input t_queue_result want);
        if (i_popped_value !== want.popped_value)
            report_mismatch("popped_value", want.popped_value, i_popped_value);
        if (i_was_empty !== want.was_empty)
            report_mismatch("was_empty", DATA_W'(want.was_empty), DATA_W'(i_was_empty));
        if (i_was_full !== want.was_full)
            report_mismatch("was_full", DATA_W'(want.was_full), DATA_W'(i_was_full));
        if (i_occupancy !== want.occupancy)
            report_mismatch("occupancy", DATA_W'(want.occupancy), DATA_W'(i_occupancy));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_seq.delete();
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no request outstanding", '0, i_popped_value);
                else
                    check_result(awaited_results.pop_front());
            end
            if (i_in_valid && i_in_ready) begin
                predicted       = apply_request(i_operation, i_push_value);
                awaited_results = {awaited_results, predicted};
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule : fmbq_checker

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Front-middle-back queue testbench
// Drives directed and random push and pop requests in bursts, stalls the
// result side on its own pattern with long hold-offs, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import fmbq_pkg::*;

    localparam int                RANDOM_ITEMS   = 1300;
    localparam int                WATCHDOG_LIMIT = 3000;
    localparam int                HOLD_PERIOD    = 15000;
    localparam int                HOLD_START     = 3000;
    localparam int                HOLD_LEN       = 400;
    localparam logic [OP_W-1:0]   OP_UNUSED_LO   = 3'd6;
    localparam logic [OP_W-1:0]   OP_UNUSED_HI   = 3'd7;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_operation;
    logic signed [DATA_W-1:0] i_push_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [DATA_W-1:0] o_popped_value;
    logic                     o_was_empty;
    logic                     o_was_full;
    logic [OCC_W-1:0]         o_occupancy;
    int                       fail_count;
    int                       pending_count;
    int                       idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    front_middle_back_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_was_empty    (o_was_empty),
        .o_was_full     (o_was_full),
        .o_occupancy    (o_occupancy)
    );

    fmbq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_popped_value (o_popped_value),
        .i_was_empty    (o_was_empty),
        .i_was_full     (o_was_full),
        .i_occupancy    (o_occupancy),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    task automatic offer_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_push_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pause_sender(input int unsigned gap);
        i_in_valid   <= 1'b0;
        i_operation  <= OP_W'($urandom_range(0, 7));
        i_push_value <= $urandom;
        repeat (gap) @(posedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int unsigned push_pct);
        int unsigned roll;
        int unsigned where;
        roll  = $urandom_range(0, 99);
        where = $urandom_range(0, 2);
        if (roll < 3)
            return (where == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
        if ($urandom_range(0, 99) < push_pct)
            return (where == 0) ? OP_PUSH_FRONT : (where == 1) ? OP_PUSH_MIDDLE : OP_PUSH_BACK;
        return (where == 0) ? OP_POP_FRONT : (where == 1) ? OP_POP_MIDDLE : OP_POP_BACK;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // hold off the result side for long stretches so the block backs up
    initial begin : receiver
        int unsigned cyc;
        int unsigned mode;
        int unsigned stretch;
        cyc = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            repeat (stretch) begin
                cyc++;
                if (cyc % HOLD_PERIOD == HOLD_START) begin
                    i_out_ready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge i_clk);
                end
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    2:       i_out_ready <= ((cyc % 7) < 3);
                    default: i_out_ready <= $urandom_range(0, 1);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned burst;
        int unsigned phase_left;
        int unsigned push_pct;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= OP_PUSH_FRONT;
        i_push_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_request(OP_POP_FRONT,   32'h1234_5678);
        offer_request(OP_POP_MIDDLE,  32'hFFFF_FFFF);
        offer_request(OP_POP_BACK,    32'h0000_0000);
        offer_request(OP_UNUSED_LO,   32'hDEAD_BEEF);
        offer_request(OP_UNUSED_HI,   32'h8000_0000);
        offer_request(OP_PUSH_MIDDLE, 32'h7FFF_FFFF);
        offer_request(OP_POP_MIDDLE,  32'h0000_0000);
        offer_request(OP_PUSH_FRONT,  32'h8000_0000);
        offer_request(OP_PUSH_BACK,   32'h0000_0000);
        offer_request(OP_PUSH_MIDDLE, 32'hFFFF_FFFF);
        offer_request(OP_PUSH_MIDDLE, 32'h5A5A_5A5A);
        offer_request(OP_UNUSED_HI,   32'h0F0F_0F0F);
        offer_request(OP_POP_MIDDLE,  32'h1111_1111);
        offer_request(OP_POP_FRONT,   32'h2222_2222);
        offer_request(OP_POP_BACK,    32'h3333_3333);
        offer_request(OP_POP_MIDDLE,  32'h4444_4444);
        offer_request(OP_POP_BACK,    32'h5555_5555);
        offer_request(OP_PUSH_BACK,   32'hA5A5_A5A5);
        offer_request(OP_PUSH_FRONT,  32'h0000_0001);
        offer_request(OP_POP_FRONT,   32'h0000_0000);
        offer_request(OP_POP_FRONT,   32'h0000_0000);
        pause_sender(3);

        sent       = 0;
        phase_left = 0;
        push_pct   = 50;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 92;
                    1:       push_pct = 12;
                    2:       push_pct = 50;
                    default: push_pct = 65;
                endcase
                phase_left = $urandom_range(20, 90);
            end
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            repeat (burst) begin
                offer_request(pick_op(push_pct), pick_value());
                sent++;
                if (phase_left != 0)
                    phase_left--;
            end
            pause_sender($urandom_range(1, 8));
        end

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : tb_top
